// ===== design/hkit_pkg.sv =====
// Shared types and constants of the hashed key index table.
`timescale 1ns / 1ps
package hkit_pkg;

    localparam int KEY_W  = 64;
    localparam int HASH_W = 32;
    localparam int IDX_W  = 9;
    localparam int TB_W   = 4;
    localparam int BYTE_W = 8;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
    localparam logic [TB_W-1:0]   TB_RESET  = 4'd10;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_MISS   = 2'd1,
        ST_FULL   = 2'd2,
        ST_NOSLOT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_HASH,
        FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_WIPE,
        BK_IDLE,
        BK_PROBE,
        BK_SLOT,
        BK_KEY,
        BK_RESP
    } back_state_t;

    // hashed request handed from front to back
    typedef struct packed {
        opcode_t            op;
        logic [KEY_W-1:0]   key;
        logic [HASH_W-1:0]  hash;
    } hkit_req_t;

    // queue status seen by the producer and consumer
    typedef struct packed {
        logic empty;
        logic full;
    } hkit_qstat_t;

endpackage

// ===== design/hkit_front.sv =====
// Front end: accepts requests, normalizes the key and computes its FNV-1a hash.
`timescale 1ns / 1ps
module hkit_front
    import hkit_pkg::*;
#(
    parameter int KEY_BYTES = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              enable,
    input  logic              s_valid,
    output logic              s_ready,
    input  opcode_t           s_op,
    input  logic [KEY_W-1:0]  s_key,
    input  hkit_qstat_t       qstat,
    output logic              q_push,
    output hkit_req_t         q_data
);

    front_state_t      state_reg, state_next;
    opcode_t           op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [KEY_W-1:0]  shift_reg, shift_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [KEY_W-1:0]  norm_key;
    logic [HASH_W-1:0] mixed;
    logic              accept;

    // key ends at the first zero byte or after KEY_BYTES bytes
    always_comb begin
        logic alive;
        alive = 1'b1;
        for (int i = 0; i < KEY_W / BYTE_W; i++) begin
            if (i >= KEY_BYTES || s_key[i*BYTE_W +: BYTE_W] == '0) begin
                alive = 1'b0;
            end
            norm_key[i*BYTE_W +: BYTE_W] = alive ? s_key[i*BYTE_W +: BYTE_W] : '0;
        end
    end

    assign s_ready = (state_reg == FR_IDLE) && enable;
    assign accept  = s_valid && s_ready;
    assign mixed   = hash_reg ^ {{(HASH_W-BYTE_W){1'b0}}, shift_reg[BYTE_W-1:0]};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE: begin
                if (accept) state_next = FR_HASH;
            end
            FR_HASH: begin
                if (shift_reg[BYTE_W-1:0] == '0) state_next = FR_PUSH;
            end
            FR_PUSH: begin
                if (!qstat.full) state_next = FR_IDLE;
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_comb begin
        op_next    = op_reg;
        key_next   = key_reg;
        shift_next = shift_reg;
        hash_next  = hash_reg;
        q_push     = 1'b0;
        unique case (state_reg)
            FR_IDLE: begin
                if (accept) begin
                    op_next    = s_op;
                    key_next   = norm_key;
                    shift_next = norm_key;
                    hash_next  = FNV_BASIS;
                end
            end
            FR_HASH: begin
                // one byte per cycle; a zero low byte marks the end of the key
                if (shift_reg[BYTE_W-1:0] != '0) begin
                    hash_next  = mixed * FNV_PRIME;
                    shift_next = shift_reg >> BYTE_W;
                end
            end
            FR_PUSH: begin
                q_push = !qstat.full;
            end
            default: ;
        endcase
    end

    assign q_data = '{op: op_reg, key: key_reg, hash: hash_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg    <= op_next;
        key_reg   <= key_next;
        shift_reg <= shift_next;
        hash_reg  <= hash_next;
    end

endmodule

// ===== design/hkit_fifo.sv =====
// Two-entry queue between the hashing front end and the table engine.
`timescale 1ns / 1ps
module hkit_fifo
    import hkit_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  hkit_req_t   wr_data,
    input  logic        pop,
    output hkit_req_t   rd_data,
    output hkit_qstat_t qstat
);

    hkit_req_t  mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign qstat.empty = (cnt_reg == 2'd0);
    assign qstat.full  = (cnt_reg == 2'd2);
    assign rd_data     = mem_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) wptr_next = ~wptr_reg;
        if (pop)  rptr_next = ~rptr_reg;
        if (push && !pop)      cnt_next = cnt_reg + 2'd1;
        else if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
        if (push) mem_reg[wptr_reg] <= wr_data;
    end

endmodule

// ===== design/hkit_back.sv =====
// Table engine: slot and key memories, linear probing, clearing and the result register.
`timescale 1ns / 1ps
module hkit_back
    import hkit_pkg::*;
#(
    parameter int MAX_ENTRIES = 512,
    parameter int MAX_SLOTS   = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [TB_W-1:0]  table_bits,
    input  hkit_qstat_t      qstat,
    input  hkit_req_t        q_data,
    output logic             q_pop,
    output logic             init_done,
    output logic             m_valid,
    input  logic             m_ready,
    output status_t          m_status,
    output logic [IDX_W-1:0] m_index
);

    localparam int SLOT_AW = $clog2(MAX_SLOTS);
    localparam int EW      = $clog2(MAX_ENTRIES);
    localparam int CW      = $clog2(MAX_ENTRIES + 1);
    localparam int TB_MAX  = $clog2(MAX_SLOTS + 1) - 1;

    back_state_t        state_reg, state_next;
    opcode_t            op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [SLOT_AW-1:0] pos_reg, pos_next;
    logic [SLOT_AW-1:0] mask_reg, mask_next;
    logic [SLOT_AW:0]   nslots_reg, nslots_next;
    logic [SLOT_AW:0]   probes_reg, probes_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [SLOT_AW-1:0] wipe_reg, wipe_next;
    logic               wipe_resp_reg, wipe_resp_next;
    status_t            status_reg, status_next;
    logic [EW-1:0]      entry_reg, entry_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [IDX_W-1:0]   out_index_reg, out_index_next;

    logic [EW:0]        slot_mem [MAX_SLOTS];
    logic [KEY_W-1:0]   key_mem [MAX_ENTRIES];
    logic [EW:0]        slot_q;
    logic [KEY_W-1:0]   key_q;
    logic               slot_we;
    logic [SLOT_AW-1:0] slot_waddr;
    logic [EW:0]        slot_wdata;
    logic               key_we;

    logic [TB_W-1:0]    bits_eff;
    logic [SLOT_AW:0]   nslots_cur;
    logic               slot_used;
    logic               last_probe;
    logic [SLOT_AW-1:0] pos_step;
    logic               wipe_last;
    logic               resp_load;
    logic               full;
    logic [EW+IDX_W-1:0] entry_ext;

    // slot count in use: 2^table_bits, at least 2, at most the largest power of two that fits
    always_comb begin
        bits_eff = table_bits;
        if (table_bits == '0) bits_eff = TB_W'(1);
        else if (table_bits > TB_W'(TB_MAX)) bits_eff = TB_W'(TB_MAX);
    end
    assign nslots_cur = (SLOT_AW+1)'(1) << bits_eff;

    assign slot_used  = slot_q[EW];
    assign last_probe = (probes_reg + (SLOT_AW+1)'(1)) == nslots_reg;
    assign pos_step   = (pos_reg + SLOT_AW'(1)) & mask_reg;
    assign wipe_last  = wipe_reg == SLOT_AW'(MAX_SLOTS - 1);
    assign resp_load  = (state_reg == BK_RESP) && (!out_valid_reg || m_ready);
    assign full       = count_reg == CW'(MAX_ENTRIES);
    assign entry_ext  = {{IDX_W{1'b0}}, entry_reg};
    assign init_done  = !((state_reg == BK_WIPE) && !wipe_resp_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_WIPE: begin
                if (wipe_last) state_next = wipe_resp_reg ? BK_RESP : BK_IDLE;
            end
            BK_IDLE: begin
                if (!qstat.empty) begin
                    unique case (q_data.op)
                        OP_CLEAR:  state_next = BK_WIPE;
                        OP_INSERT: state_next = full ? BK_RESP : BK_PROBE;
                        OP_LOOKUP: state_next = BK_PROBE;
                        default:   state_next = BK_RESP;
                    endcase
                end
            end
            BK_PROBE: state_next = BK_SLOT;
            BK_SLOT: begin
                if (op_reg == OP_INSERT) begin
                    if (!slot_used || last_probe) state_next = BK_RESP;
                    else state_next = BK_PROBE;
                end else begin
                    state_next = slot_used ? BK_KEY : BK_RESP;
                end
            end
            BK_KEY: begin
                if (key_q == key_reg || last_probe) state_next = BK_RESP;
                else state_next = BK_PROBE;
            end
            BK_RESP: begin
                if (resp_load) state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        op_next         = op_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        mask_next       = mask_reg;
        nslots_next     = nslots_reg;
        probes_next     = probes_reg;
        count_next      = count_reg;
        wipe_next       = wipe_reg;
        wipe_resp_next  = wipe_resp_reg;
        status_next     = status_reg;
        entry_next      = entry_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        q_pop           = 1'b0;
        slot_we         = 1'b0;
        slot_waddr      = pos_reg;
        slot_wdata      = {1'b1, count_reg[EW-1:0]};
        key_we          = 1'b0;

        if (m_ready) out_valid_next = 1'b0;

        unique case (state_reg)
            BK_WIPE: begin
                slot_we    = 1'b1;
                slot_waddr = wipe_reg;
                slot_wdata = '0;
                wipe_next  = wipe_reg + SLOT_AW'(1);
                count_next = '0;
                status_next = ST_OK;
                entry_next  = '0;
            end
            BK_IDLE: begin
                if (!qstat.empty) begin
                    q_pop       = 1'b1;
                    op_next     = q_data.op;
                    key_next    = q_data.key;
                    mask_next   = SLOT_AW'(nslots_cur - (SLOT_AW+1)'(1));
                    nslots_next = nslots_cur;
                    pos_next    = q_data.hash[SLOT_AW-1:0]
                                  & SLOT_AW'(nslots_cur - (SLOT_AW+1)'(1));
                    probes_next = '0;
                    entry_next  = '0;
                    status_next = ST_MISS;
                    unique case (q_data.op)
                        OP_CLEAR: begin
                            wipe_next      = '0;
                            wipe_resp_next = 1'b1;
                        end
                        OP_INSERT: begin
                            if (full) status_next = ST_FULL;
                        end
                        default: ;
                    endcase
                end
            end
            BK_PROBE: ;
            BK_SLOT: begin
                if (op_reg == OP_INSERT) begin
                    if (!slot_used) begin
                        slot_we     = 1'b1;
                        key_we      = 1'b1;
                        entry_next  = count_reg[EW-1:0];
                        count_next  = count_reg + CW'(1);
                        status_next = ST_OK;
                    end else if (last_probe) begin
                        status_next = ST_NOSLOT;
                    end else begin
                        pos_next    = pos_step;
                        probes_next = probes_reg + (SLOT_AW+1)'(1);
                    end
                end
            end
            BK_KEY: begin
                if (key_q == key_reg) begin
                    status_next = ST_OK;
                    entry_next  = slot_q[EW-1:0];
                end else if (!last_probe) begin
                    pos_next    = pos_step;
                    probes_next = probes_reg + (SLOT_AW+1)'(1);
                end
            end
            BK_RESP: begin
                if (resp_load) begin
                    wipe_resp_next  = 1'b0;
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_index_next  = (status_reg == ST_OK) ? entry_ext[IDX_W-1:0] : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
        slot_q <= slot_mem[pos_reg];
    end

    always_ff @(posedge aclk) begin
        if (key_we) key_mem[count_reg[EW-1:0]] <= key_reg;
        key_q <= key_mem[slot_q[EW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_WIPE;
            wipe_reg      <= '0;
            wipe_resp_reg <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wipe_reg      <= wipe_next;
            wipe_resp_reg <= wipe_resp_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        op_reg         <= op_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        mask_reg       <= mask_next;
        nslots_reg     <= nslots_next;
        probes_reg     <= probes_next;
        status_reg     <= status_next;
        entry_reg      <= entry_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_index  = out_index_reg;

endmodule

// ===== design/hashed_key_index_table.sv =====
// Top level of the hashed key index table: stream ports, register port and the three stages.
// Maps keys of up to KEY_BYTES bytes to entry numbers through an open-addressed table
// with linear probing on the 32-bit FNV-1a hash. A request is first hashed in the hash
// unit, one key byte at a time (one multiply per cycle). The table engine then probes
// slot after slot, through states PROBE, SLOT and KEY for lookups and PROBE and SLOT
// for inserts, and at last loads the result register. The front end hashes the next
// request while the table engine works on the current one. A clear request sweeps every
// slot. After reset the same sweep runs, during which s_axis_tready stays low; register
// writes are taken throughout.
`timescale 1ns / 1ps
module hashed_key_index_table
    import hkit_pkg::*;
#(
    parameter int MAX_ENTRIES = 512,
    parameter int MAX_SLOTS   = 1024,
    parameter int KEY_BYTES   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // opcode [1:0], key_text [65:2], zero [71:66]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // status [1:0], entry_index [10:2], zero [15:11]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [TB_W-1:0]  table_bits_reg, table_bits_next;
    logic             init_done;
    hkit_qstat_t      qstat;
    logic             q_push, q_pop;
    hkit_req_t        q_wdata, q_rdata;
    status_t          m_status;
    logic [IDX_W-1:0] m_index;
    logic             reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'b0);
    assign prdata  = reg_hit ? {28'd0, table_bits_reg} : 32'd0;

    always_comb begin
        table_bits_next = table_bits_reg;
        if (psel && penable && pwrite && pready && reg_hit) table_bits_next = pwdata[TB_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) table_bits_reg <= TB_RESET;
        else          table_bits_reg <= table_bits_next;
    end

    hkit_front #(
        .KEY_BYTES (KEY_BYTES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .enable  (init_done),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_op    (opcode_t'(s_axis_tdata[1:0])),
        .s_key   (s_axis_tdata[65:2]),
        .qstat   (qstat),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    hkit_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wdata),
        .pop     (q_pop),
        .rd_data (q_rdata),
        .qstat   (qstat)
    );

    hkit_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_SLOTS   (MAX_SLOTS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .table_bits (table_bits_reg),
        .qstat      (qstat),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .init_done  (init_done),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_status   (m_status),
        .m_index    (m_index)
    );

    assign m_axis_tdata = {5'd0, m_index, m_status};

endmodule

// ===== design/hkit_checker.sv =====
// Port-level checks of the hashed key index table, bound to the top level.
`timescale 1ns / 1ps
module hkit_checker
    import hkit_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        pready
);

    // a result other than ok carries entry number zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK) |-> (m_axis_tdata[10:2] == '0))
        else $error("nonzero entry on failed request");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[15:11] == '0))
        else $error("result padding not zero");

    // nothing comes out right after reset: the slot sweep runs first
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result dropped or changed");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind hashed_key_index_table hkit_checker u_hkit_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);

// ===== bench/hashed_key_index_table_test.sv =====
// Self-checking testbench of the hashed key index table: stream stimulus, predictor, checker.
`timescale 1ns / 1ps
module hashed_key_index_table_test;
    import hkit_pkg::*;

    localparam int        N_ENTRIES      = 512;
    localparam int        N_SLOTS        = 1024;
    localparam logic [2:0] REG_TABLE_BITS = 3'd0;
    localparam int        STALL_LIMIT    = 20000;
    localparam int        ITEM_TARGET    = 1850;

    typedef struct {
        opcode_t     op;
        logic [63:0] key;
    } request_t;

    typedef struct {
        status_t    st;
        logic [8:0] idx;
    } answer_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // opcode [1:0], key_text [65:2], zero [71:66]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // status [1:0], entry_index [10:2], zero [15:11]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hashed_key_index_table u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // shadow table state
    logic [9:0]  shadow_slot [N_SLOTS];
    logic        shadow_used [N_SLOTS];
    logic [63:0] shadow_keys [N_ENTRIES];
    int          shadow_count;
    logic [3:0]  shadow_bits;

    request_t    pending_q[$];
    answer_t     answer_q[$];
    logic [63:0] key_pool[$];
    request_t    cur_req;
    bit          req_taken;
    bit          quiet;
    bit          hold_req;
    int          tx_gap;
    int          rx_gap;
    int          hold_left;
    int          err_count;
    int          sent_items;
    int          idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void wipe_table();
        for (int i = 0; i < N_SLOTS; i++) begin
            shadow_used[i] = 1'b0;
            shadow_slot[i] = '0;
        end
        shadow_count = 0;
    endfunction

    // next expected answer for one request, updating the shadow table
    function automatic answer_t predict_answer(request_t r);
        answer_t     a;
        logic [63:0] k;
        logic [31:0] h;
        int          len;
        int          bits;
        int          n;
        int          pos;
        k    = '0;
        len  = 0;
        h    = FNV_BASIS;
        for (int i = 0; i < 8; i++) begin
            if (r.key[8*i +: 8] == 8'd0) break;
            k[8*i +: 8] = r.key[8*i +: 8];
            len++;
        end
        for (int i = 0; i < len; i++) begin
            h = h ^ {24'd0, k[8*i +: 8]};
            h = h * FNV_PRIME;
        end
        bits = (shadow_bits == 0) ? 1 : shadow_bits;
        n    = 1 << bits;
        while (n > N_SLOTS) n = n >> 1;
        pos   = h & (n - 1);
        a.st  = ST_MISS;
        a.idx = '0;
        case (r.op)
            OP_CLEAR: begin
                wipe_table();
                a.st = ST_OK;
            end
            OP_INSERT: begin
                if (shadow_count >= N_ENTRIES) begin
                    a.st = ST_FULL;
                end else begin
                    a.st = ST_NOSLOT;
                    for (int p = 0; p < n; p++) begin
                        if (!shadow_used[pos]) begin
                            shadow_keys[shadow_count] = k;
                            shadow_slot[pos] = shadow_count[9:0];
                            shadow_used[pos] = 1'b1;
                            a.idx = shadow_count[8:0];
                            a.st  = ST_OK;
                            shadow_count++;
                            break;
                        end
                        pos = (pos + 1) & (n - 1);
                    end
                end
            end
            OP_LOOKUP: begin
                for (int p = 0; p < n; p++) begin
                    if (!shadow_used[pos]) break;
                    if (shadow_keys[shadow_slot[pos]] == k) begin
                        a.st  = ST_OK;
                        a.idx = shadow_slot[pos][8:0];
                        break;
                    end
                    pos = (pos + 1) & (n - 1);
                end
            end
            default: ;
        endcase
        if (a.st != ST_OK) a.idx = '0;
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // request driver
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            req_taken = 1'b1;
            answer_q.push_back(predict_answer(cur_req));
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_taken) begin
            req_taken = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_q.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
                tx_gap = $urandom_range(0, 6);
                s_axis_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                cur_req = pending_q.pop_front();
                s_axis_tdata  <= {6'd0, cur_req.key, cur_req.op};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (answer_q.size() == 0) begin
                report_mismatch("unexpected result, status", m_axis_tdata[1:0], -1);
            end else begin
                want = answer_q.pop_front();
                if (m_axis_tdata[1:0] != want.st)
                    report_mismatch("status", m_axis_tdata[1:0], want.st);
                if (m_axis_tdata[10:2] != want.idx)
                    report_mismatch("entry_index", m_axis_tdata[10:2], want.idx);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send(opcode_t op, logic [63:0] key);
        request_t r;
        r.op  = op;
        r.key = key;
        pending_q.push_back(r);
        sent_items++;
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || s_axis_tvalid || answer_q.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_table_bits(logic [3:0] bits);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TABLE_BITS;
        pwdata  <= {28'd0, bits};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_bits = bits;
    endtask

    // nonzero bytes up to a random length; sometimes junk after the terminator
    function automatic logic [63:0] random_key();
        logic [63:0] k;
        int          len;
        k   = '0;
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) k[8*i +: 8] = $urandom_range(1, 255);
        if (len < 7 && $urandom_range(0, 2) == 0)
            for (int i = len + 1; i < 8; i++) k[8*i +: 8] = $urandom_range(0, 255);
        return k;
    endfunction

    initial begin
        int       roll;
        int       n_phase;
        logic [63:0] k;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        req_taken     = 1'b0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        tx_gap        = 0;
        rx_gap        = 0;
        hold_left     = 0;
        err_count     = 0;
        sent_items    = 0;
        idle_cycles   = 0;
        wipe_table();
        shadow_bits   = TB_RESET;
        for (int i = 0; i < N_ENTRIES; i++) shadow_keys[i] = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty key, full-width key, junk past terminator, duplicates
        send(OP_LOOKUP, 64'd0);
        send(OP_INSERT, 64'd0);
        send(OP_LOOKUP, 64'd0);
        send(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        send(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
        send(OP_INSERT, 64'h0000_0000_0000_0041);
        send(OP_LOOKUP, 64'hDEAD_BEEF_0000_0041);
        send(OP_INSERT, 64'h0000_0000_0000_0041);
        send(OP_LOOKUP, 64'h0000_0000_0000_0041);
        send(OP_LOOKUP, 64'h0000_0000_0000_4241);
        send(OP_NONE,   64'hFFFF_FFFF_FFFF_FFFF);
        send(OP_INSERT, 64'h0102_0304_0506_0708);
        send(OP_CLEAR,  64'hFFFF_FFFF_FFFF_FFFF);
        send(OP_LOOKUP, 64'h0000_0000_0000_0041);
        drain();

        // zero bits act as a two-slot table: third insert finds no slot
        write_table_bits(4'd0);
        send(OP_INSERT, 64'h61);
        send(OP_INSERT, 64'h62);
        send(OP_INSERT, 64'h63);
        send(OP_LOOKUP, 64'h62);
        send(OP_LOOKUP, 64'h63);
        drain();
        // resize without clear: placed entries stay put
        write_table_bits(4'd15);
        send(OP_LOOKUP, 64'h61);
        send(OP_LOOKUP, 64'h62);
        send(OP_INSERT, 64'h64);
        drain();

        // fill the entry store under a long receiver stall
        write_table_bits(4'd10);
        send(OP_CLEAR, 64'd0);
        drain();
        hold_req = 1'b1;
        for (int i = 0; i < N_ENTRIES + 2; i++) begin
            k = random_key();
            key_pool.push_back(k);
            send(OP_INSERT, k);
        end
        for (int i = 0; i < 20; i++)
            send(OP_LOOKUP, key_pool[$urandom_range(0, key_pool.size() - 1)]);
        drain();

        while (sent_items < ITEM_TARGET) begin
            roll = $urandom_range(0, 11);
            write_table_bits(roll == 11 ? 4'd15 : roll[3:0]);
            if (sent_items > ITEM_TARGET - 200) quiet = 1'b1;
            key_pool.delete();
            send(OP_CLEAR, random_key());
            n_phase = $urandom_range(60, 160);
            for (int i = 0; i < n_phase; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    k = random_key();
                    key_pool.push_back(k);
                    send(OP_INSERT, k);
                end else if (roll < 85 && key_pool.size() > 0) begin
                    send(OP_LOOKUP, key_pool[$urandom_range(0, key_pool.size() - 1)]);
                end else if (roll < 95) begin
                    send(OP_LOOKUP, random_key());
                end else if (roll < 98) begin
                    send(OP_NONE, random_key());
                end else begin
                    key_pool.delete();
                    send(OP_CLEAR, random_key());
                end
            end
            drain();
        end

        drain();
        repeat (50) @(posedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
